// File: rtl/pqls_pkg.sv
// Types and fixed constants shared by the priority queue core.
package pqls_pkg;

  // Field widths of one queue entry and of the stream payloads.
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned PRIO_W      = 16;
  localparam int unsigned ENTRY_W     = VALUE_W + PRIO_W;
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned COUNT_W     = 5;
  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned OUT_TDATA_W = 40;

  // Operation codes carried by an input transaction.
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_PEEK = 2'd2
  } cmd_e;

  // Status codes reported with every result.
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

endpackage

// File: rtl/priority_queue_linear_scan_core.sv
// Push, unused command, pop or peek on an empty store: no scan; the sequencer goes straight to the done state.
// Peek with n entries: the scan reads and compares the n entries in turn (one RAM read and compare per entry).
// Pop then moves the later entries down one place when the chosen entry k is not the last.
// A new transaction is taken in the cycle after the result is loaded into the output register.
// Reset clears the entry count and the output valid; the entry RAM holds no reset value.
module priority_queue_linear_scan_core #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // cmd [1:0], value_in [33:2], priority_in [49:34], zero [55:50]
  input  logic [pqls_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // value_out [31:0], status [33:32], count [38:34], zero [39]
  output logic [pqls_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready
);

  localparam int unsigned AddrW = $clog2(CAPACITY);
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam logic [CntW-1:0] CapCnt = CntW'(CAPACITY);

  // Input transaction fields.
  logic [pqls_pkg::CMD_W-1:0]   in_cmd;
  logic [pqls_pkg::VALUE_W-1:0] in_value;
  logic [pqls_pkg::PRIO_W-1:0]  in_prio;
  logic                         accept;

  assign in_cmd   = s_axis_tdata[1:0];
  assign in_value = s_axis_tdata[33:2];
  assign in_prio  = s_axis_tdata[49:34];

  // Sequencer and datapath registers.
  pqls_pkg::state_e              state_q, state_d;
  logic [CntW-1:0]               count_q, count_d;
  logic                          is_pop_q, is_pop_d;
  logic [pqls_pkg::VALUE_W-1:0]  res_value_q, res_value_d;
  pqls_pkg::status_e             res_status_q, res_status_d;
  logic [pqls_pkg::PRIO_W-1:0]   best_prio_q, best_prio_d;
  logic [AddrW-1:0]              best_idx_q, best_idx_d;
  logic [AddrW-1:0]              data_idx_q, data_idx_d;
  logic [CntW-1:0]               src_q, src_d;
  logic [AddrW-1:0]              dst_q, dst_d;
  logic                          pend_q, pend_d;
  logic                          m_tvalid_q, m_tvalid_d;
  logic [pqls_pkg::OUT_TDATA_W-1:0] m_tdata_q, m_tdata_d;

  // Entry RAM ports.
  logic                          ram_we;
  logic [AddrW-1:0]              ram_waddr;
  logic [pqls_pkg::ENTRY_W-1:0]  ram_wdata;
  logic [AddrW-1:0]              ram_raddr;
  logic [pqls_pkg::ENTRY_W-1:0]  ram_rdata;
  logic [pqls_pkg::VALUE_W-1:0]  rd_value;
  logic [pqls_pkg::PRIO_W-1:0]   rd_prio;

  // Scan and shift helpers.
  logic                          take;
  logic                          last;
  logic [CntW-1:0]               src_dec;
  logic [CntW+pqls_pkg::COUNT_W-1:0] count_wide;

  assign rd_value   = ram_rdata[pqls_pkg::VALUE_W-1:0];
  assign rd_prio    = ram_rdata[pqls_pkg::ENTRY_W-1:pqls_pkg::VALUE_W];
  assign count_wide = (CntW + pqls_pkg::COUNT_W)'(count_q);
  assign src_dec    = src_q - CntW'(1);

  assign s_axis_tready = (state_q == pqls_pkg::S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;

  pqls_ram #(
    .WIDTH (pqls_pkg::ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequencer: in the scan state, one RAM read and one priority compare per cycle.
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    is_pop_d     = is_pop_q;
    res_value_d  = res_value_q;
    res_status_d = res_status_q;
    best_prio_d  = best_prio_q;
    best_idx_d   = best_idx_q;
    data_idx_d   = data_idx_q;
    src_d        = src_q;
    dst_d        = dst_q;
    pend_d       = pend_q;
    m_tvalid_d   = m_tvalid_q;
    m_tdata_d    = m_tdata_q;
    ram_we       = 1'b0;
    ram_waddr    = dst_q;
    ram_wdata    = ram_rdata;
    ram_raddr    = '0;
    take         = (data_idx_q == '0) || (rd_prio > best_prio_q);
    last         = ((CntW'(data_idx_q) + CntW'(1)) == count_q);

    // The output register empties when its transaction completes.
    if (m_axis_tready) begin
      m_tvalid_d = 1'b0;
    end

    case (state_q)
      pqls_pkg::S_IDLE: begin
        if (accept) begin
          is_pop_d     = (in_cmd == pqls_pkg::CMD_POP);
          res_value_d  = '0;
          res_status_d = pqls_pkg::STAT_OK;
          data_idx_d   = '0;
          state_d      = pqls_pkg::S_DONE;
          if (in_cmd == pqls_pkg::CMD_PUSH) begin
            if (count_q == CapCnt) begin
              res_status_d = pqls_pkg::STAT_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = count_q[AddrW-1:0];
              ram_wdata = {in_prio, in_value};
              count_d   = count_q + CntW'(1);
            end
          end else if ((in_cmd == pqls_pkg::CMD_POP) || (in_cmd == pqls_pkg::CMD_PEEK)) begin
            if (count_q == '0) begin
              res_value_d  = '1;
              res_status_d = pqls_pkg::STAT_EMPTY;
            end else begin
              // Entry 0 is read now and compared in the first scan cycle.
              state_d = pqls_pkg::S_SCAN;
            end
          end
        end
      end

      pqls_pkg::S_SCAN: begin
        // Strictly greater replaces, so the earliest entry wins a tie.
        if (take) begin
          res_value_d = rd_value;
          best_prio_d = rd_prio;
          best_idx_d  = data_idx_q;
        end
        if (!last) begin
          ram_raddr  = data_idx_q + AddrW'(1);
          data_idx_d = data_idx_q + AddrW'(1);
        end else if (!is_pop_q) begin
          state_d = pqls_pkg::S_DONE;
        end else begin
          src_d  = CntW'(best_idx_d) + CntW'(1);
          pend_d = 1'b0;
          if (src_d == count_q) begin
            count_d = count_q - CntW'(1);
            state_d = pqls_pkg::S_DONE;
          end else begin
            state_d = pqls_pkg::S_SHIFT;
          end
        end
      end

      pqls_pkg::S_SHIFT: begin
        // Each entry read here is written one place lower in the next cycle.
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = dst_q;
          ram_wdata = ram_rdata;
        end
        if (src_q < count_q) begin
          ram_raddr = src_q[AddrW-1:0];
          dst_d     = src_dec[AddrW-1:0];
          src_d     = src_q + CntW'(1);
          pend_d    = 1'b1;
        end else begin
          count_d = count_q - CntW'(1);
          state_d = pqls_pkg::S_DONE;
        end
      end

      pqls_pkg::S_DONE: begin
        if (!m_tvalid_q || m_axis_tready) begin
          m_tvalid_d = 1'b1;
          m_tdata_d  = {1'b0, count_wide[pqls_pkg::COUNT_W-1:0], res_status_q, res_value_q};
          state_d    = pqls_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = pqls_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= pqls_pkg::S_IDLE;
      count_q    <= '0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      m_tvalid_q <= m_tvalid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    is_pop_q     <= is_pop_d;
    res_value_q  <= res_value_d;
    res_status_q <= res_status_d;
    best_prio_q  <= best_prio_d;
    best_idx_q   <= best_idx_d;
    data_idx_q   <= data_idx_d;
    src_q        <= src_d;
    dst_q        <= dst_d;
    pend_q       <= pend_d;
    m_tdata_q    <= m_tdata_d;
  end

  // The entry count never goes past the capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapCnt)
    else $error("entry count exceeds capacity");

  // A push into a store with room grows the count by one.
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_cmd == pqls_pkg::CMD_PUSH) && (count_q != CapCnt))
    |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("push did not grow the entry count");

  // The scan only compares entries that are held.
  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pqls_pkg::S_SCAN) |-> (CntW'(data_idx_q) < count_q))
    else $error("scan index beyond held entries");

  // A finished result waits while the output register is still occupied.
  a_done_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == pqls_pkg::S_DONE) && m_tvalid_q && !m_axis_tready)
    |=> (state_q == pqls_pkg::S_DONE))
    else $error("result overwrote an untaken transaction");

  // An empty status goes with a value of minus one and a count of zero.
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_q && (m_tdata_q[33:32] == pqls_pkg::STAT_EMPTY))
    |-> ((m_tdata_q[31:0] == '1) && (m_tdata_q[38:34] == '0)))
    else $error("empty result with wrong value or count");

endmodule

// File: rtl/pqls_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
module pqls_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
